/* rtl/tgard_pkg.sv */
`default_nettype none

package tgard_pkg;

    // Header layout: twelve signature bytes, then width, height, depth and descriptor.
    localparam int unsigned SIG_LEN = 12;

    localparam logic [4:0] HDR_SIG_LAST  = 5'd11;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_DESC      = 5'd17;
    localparam logic [4:0] HDR_DONE      = 5'd18;

    // Signatures of a run-length coded and of a raw true-color file.
    localparam logic [7:0] SIG_RLE [SIG_LEN] =
        '{8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    localparam logic [7:0] SIG_RAW [SIG_LEN] =
        '{8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

    // Packet byte decoding.
    localparam logic [7:0] PACKET_RAW_BIAS    = 8'd1;
    localparam logic [7:0] PACKET_REPEAT_BIAS = 8'd127;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    // One accepted input beat.
    typedef struct packed {
        logic       first_byte;
        logic [7:0] byte_value;
    } item_t;

    // One result beat.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [2:0]  pixel_bytes;
        logic [31:0] pixel;
        logic [7:0]  run_length;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/tgard_in_stage.sv */
`default_nettype none

module tgard_in_stage
    import tgard_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // A held beat moves on when the parser takes it; a new beat can enter the same cycle.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register loads on every accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* rtl/tgard_parser.sv */
`default_nettype none

module tgard_parser
    import tgard_pkg::*;
#(
    parameter int unsigned MAX_PIXEL_BYTES = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire item_t item,
    output logic       res_valid,
    output result_t    res
);

    localparam int unsigned PIX_W = MAX_PIXEL_BYTES * 8;

    logic [4:0]       header_index_reg, header_index_next;
    logic             rle_mode_reg, rle_mode_next;
    logic             sig_rle_ok_reg, sig_rle_ok_next;
    logic             sig_raw_ok_reg, sig_raw_ok_next;
    logic [15:0]      image_width_reg, image_width_next;
    logic [15:0]      image_height_reg, image_height_next;
    logic [2:0]       pixel_size_reg, pixel_size_next;
    logic [31:0]      pixels_left_reg, pixels_left_next;
    logic [7:0]       packet_left_reg, packet_left_next;
    logic             packet_repeat_reg, packet_repeat_next;
    logic [1:0]       byte_in_pixel_reg, byte_in_pixel_next;
    logic [PIX_W-1:0] pixel_buffer_reg, pixel_buffer_next;
    logic             stopped_reg, stopped_next;

    // State as seen by this beat, after a restart on a first byte.
    logic [4:0]       cur_index;
    logic             cur_rle_mode;
    logic             cur_rle_ok;
    logic             cur_raw_ok;
    logic [15:0]      cur_width;
    logic [15:0]      cur_height;
    logic [2:0]       cur_size;
    logic [31:0]      cur_pixels_left;
    logic [7:0]       cur_packet_left;
    logic             cur_repeat;
    logic [1:0]       cur_bip;
    logic [PIX_W-1:0] cur_buffer;
    logic             cur_stopped;

    always_comb
    begin
        if (item.first_byte)
        begin
            cur_index       = '0;
            cur_rle_mode    = 1'b0;
            cur_rle_ok      = 1'b1;
            cur_raw_ok      = 1'b1;
            cur_width       = '0;
            cur_height      = '0;
            cur_size        = '0;
            cur_pixels_left = '0;
            cur_packet_left = '0;
            cur_repeat      = 1'b0;
            cur_bip         = '0;
            cur_buffer      = '0;
            cur_stopped     = 1'b0;
        end
        else
        begin
            cur_index       = header_index_reg;
            cur_rle_mode    = rle_mode_reg;
            cur_rle_ok      = sig_rle_ok_reg;
            cur_raw_ok      = sig_raw_ok_reg;
            cur_width       = image_width_reg;
            cur_height      = image_height_reg;
            cur_size        = pixel_size_reg;
            cur_pixels_left = pixels_left_reg;
            cur_packet_left = packet_left_reg;
            cur_repeat      = packet_repeat_reg;
            cur_bip         = byte_in_pixel_reg;
            cur_buffer      = pixel_buffer_reg;
            cur_stopped     = stopped_reg;
        end
    end

    // Pixel buffer with this beat's byte placed in its lane.
    logic [PIX_W-1:0] buffer_fill;

    always_comb
    begin
        buffer_fill = cur_buffer;
        for (int k = 0; k < MAX_PIXEL_BYTES; k++)
        begin
            if (cur_bip == 2'(k))
            begin
                buffer_fill[k*8 +: 8] = item.byte_value;
            end
        end
    end

    // Per-beat decode: header parsing or pixel data.
    logic [3:0] sig_idx;
    logic       rle_match;
    logic       raw_match;
    logic [4:0] depth_bytes;
    logic [7:0] packet_run;
    logic [7:0] pixel_run;
    logic [31:0] pixels_after;

    assign sig_idx     = cur_index[3:0];
    assign depth_bytes = item.byte_value[7:3];

    always_comb
    begin
        header_index_next  = cur_index;
        rle_mode_next      = cur_rle_mode;
        sig_rle_ok_next    = cur_rle_ok;
        sig_raw_ok_next    = cur_raw_ok;
        image_width_next   = cur_width;
        image_height_next  = cur_height;
        pixel_size_next    = cur_size;
        pixels_left_next   = cur_pixels_left;
        packet_left_next   = cur_packet_left;
        packet_repeat_next = cur_repeat;
        byte_in_pixel_next = cur_bip;
        pixel_buffer_next  = cur_buffer;
        stopped_next       = cur_stopped;
        res_valid          = 1'b0;
        res                = '0;
        rle_match          = 1'b0;
        raw_match          = 1'b0;
        packet_run         = '0;
        pixel_run          = '0;
        pixels_after       = '0;

        if (!cur_stopped)
        begin
            if (cur_index < HDR_DONE)
            begin
                priority if (cur_index <= HDR_SIG_LAST)
                begin
                    rle_match       = cur_rle_ok && (item.byte_value == SIG_RLE[sig_idx]);
                    raw_match       = cur_raw_ok && (item.byte_value == SIG_RAW[sig_idx]);
                    sig_rle_ok_next = rle_match;
                    sig_raw_ok_next = raw_match;
                    if (!rle_match && !raw_match)
                    begin
                        res_valid    = 1'b1;
                        res.kind     = KIND_ERROR;
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        header_index_next = cur_index + 5'd1;
                        if (cur_index == HDR_SIG_LAST)
                        begin
                            rle_mode_next = rle_match;
                        end
                    end
                end
                else if (cur_index == HDR_WIDTH_LO)
                begin
                    image_width_next  = {8'd0, item.byte_value};
                    header_index_next = cur_index + 5'd1;
                end
                else if (cur_index == HDR_WIDTH_HI)
                begin
                    image_width_next  = {item.byte_value, cur_width[7:0]};
                    header_index_next = cur_index + 5'd1;
                end
                else if (cur_index == HDR_HEIGHT_LO)
                begin
                    image_height_next = {8'd0, item.byte_value};
                    header_index_next = cur_index + 5'd1;
                end
                else if (cur_index == HDR_HEIGHT_HI)
                begin
                    image_height_next = {item.byte_value, cur_height[7:0]};
                    header_index_next = cur_index + 5'd1;
                end
                else if (cur_index == HDR_DEPTH)
                begin
                    if ((depth_bytes == 5'd0) || (depth_bytes > 5'(MAX_PIXEL_BYTES)))
                    begin
                        res_valid    = 1'b1;
                        res.kind     = KIND_ERROR;
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        pixel_size_next   = depth_bytes[2:0];
                        header_index_next = cur_index + 5'd1;
                    end
                end
                else
                begin
                    // Descriptor byte: the header is complete.
                    pixels_left_next    = 32'(cur_width) * 32'(cur_height);
                    packet_left_next    = '0;
                    packet_repeat_next  = 1'b0;
                    byte_in_pixel_next  = '0;
                    pixel_buffer_next   = '0;
                    header_index_next   = HDR_DONE;
                    res_valid           = 1'b1;
                    res.kind            = KIND_HEADER;
                    res.width           = cur_width;
                    res.height          = cur_height;
                    res.pixel_bytes     = cur_size;
                    if ((cur_width == 16'd0) || (cur_height == 16'd0))
                    begin
                        res.last     = 1'b1;
                        stopped_next = 1'b1;
                    end
                end
            end
            else if (cur_rle_mode && (cur_packet_left == 8'd0) && (cur_bip == 2'd0))
            begin
                // Packet byte: run length and raw or repeat mode.
                if (item.byte_value[7])
                begin
                    packet_run = item.byte_value - PACKET_REPEAT_BIAS;
                end
                else
                begin
                    packet_run = item.byte_value + PACKET_RAW_BIAS;
                end
                if ({24'd0, packet_run} > cur_pixels_left)
                begin
                    packet_run = cur_pixels_left[7:0];
                end
                packet_left_next   = packet_run;
                packet_repeat_next = item.byte_value[7];
            end
            else if (({1'b0, cur_bip} + 3'd1) < cur_size)
            begin
                pixel_buffer_next  = buffer_fill;
                byte_in_pixel_next = cur_bip + 2'd1;
            end
            else
            begin
                // Last byte of a pixel: emit it.
                if (cur_rle_mode && cur_repeat)
                begin
                    pixel_run        = cur_packet_left;
                    packet_left_next = '0;
                end
                else
                begin
                    pixel_run = 8'd1;
                    if (cur_rle_mode)
                    begin
                        packet_left_next = cur_packet_left - 8'd1;
                    end
                end
                pixels_after       = cur_pixels_left - {24'd0, pixel_run};
                pixels_left_next   = pixels_after;
                res_valid          = 1'b1;
                res.kind           = KIND_PIXEL;
                res.pixel          = 32'(buffer_fill);
                res.run_length     = pixel_run;
                byte_in_pixel_next = '0;
                pixel_buffer_next  = '0;
                if (pixels_after == 32'd0)
                begin
                    res.last     = 1'b1;
                    stopped_next = 1'b1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg  <= '0;
            rle_mode_reg      <= 1'b0;
            sig_rle_ok_reg    <= 1'b1;
            sig_raw_ok_reg    <= 1'b1;
            pixel_size_reg    <= '0;
            pixels_left_reg   <= '0;
            packet_left_reg   <= '0;
            packet_repeat_reg <= 1'b0;
            byte_in_pixel_reg <= '0;
            stopped_reg       <= 1'b1;
        end
        else if (step)
        begin
            header_index_reg  <= header_index_next;
            rle_mode_reg      <= rle_mode_next;
            sig_rle_ok_reg    <= sig_rle_ok_next;
            sig_raw_ok_reg    <= sig_raw_ok_next;
            pixel_size_reg    <= pixel_size_next;
            pixels_left_reg   <= pixels_left_next;
            packet_left_reg   <= packet_left_next;
            packet_repeat_reg <= packet_repeat_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            stopped_reg       <= stopped_next;
        end
    end

    // Header fields and pixel bytes; every use follows a restart that clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= '0;
            image_height_reg <= '0;
            pixel_buffer_reg <= '0;
        end
        else if (step)
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            pixel_buffer_reg <= pixel_buffer_next;
        end
    end

    // A stopped parser only wakes on a first byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.first_byte && stopped_reg |-> !res_valid)
        else $error("result produced while stopped");

    // Completing the image or an error stops the parser.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && (res.last || (res.kind == KIND_ERROR)) |=> stopped_reg)
        else $error("parser not stopped after final result");

    // The header result only follows the descriptor byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res_valid && (res.kind == KIND_HEADER)
            |-> !item.first_byte && (header_index_reg == HDR_DESC))
        else $error("header result at wrong header position");

    // While decoding data, the byte lane stays inside the pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        !stopped_reg && (header_index_reg == HDR_DONE)
            |-> ({1'b0, byte_in_pixel_reg} < pixel_size_reg))
        else $error("byte lane beyond pixel size");

    // A packet never exceeds the longest run a packet byte can code.
    assert property (@(posedge clk) disable iff (!rst_n)
        packet_left_reg <= 8'd128)
        else $error("packet count out of range");

endmodule

`default_nettype wire

/* rtl/tgard_out_stage.sv */
`default_nettype none

module tgard_out_stage
    import tgard_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         slot_free,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The register can take a result when empty or when its beat leaves this cycle.
    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        if (step)
        begin
            valid_next = res_valid;
        end
        else
        begin
            valid_next = valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

/* rtl/tga_rle_image_decoder_top.sv */
// TGA image stream decoder.
// Input channel (in_valid/in_ready): one file byte per beat in byte_value, with
// first_byte high on byte 0 of a file; that beat restarts parsing at any time.
// Output channel (out_valid/out_ready): one beat for the header (kind header,
// width, height, pixel_bytes), one per pixel run (kind pixel, pixel,
// run_length), or one for a bad signature or depth (kind error). The beat that
// completes the image carries last. Header bytes and packet bytes give no beat.
// Each accepted byte is held in the input register and decoded into the result
// register once that register can take it. Throughput: one byte per cycle while
// the receiver accepts results; out_ready low stalls the flow.
// Reset clears both registers and leaves the parser stopped: bytes are dropped
// until one with first_byte high. Bytes after the last pixel or an error are
// dropped the same way. When the receiver stalls, the held result stays and
// one more byte waits in the input register, then in_ready falls.
`default_nettype none

module tga_rle_image_decoder_top
    import tgard_pkg::*;
#(
    parameter int unsigned MAX_PIXEL_BYTES = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_value,
    input  wire logic        first_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [15:0]      width,
    output logic [15:0]      height,
    output logic [2:0]       pixel_bytes,
    output logic [31:0]      pixel,
    output logic [7:0]       run_length,
    output logic             last
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    slot_free;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_item.byte_value = byte_value;
    assign in_item.first_byte = first_byte;

    // A held byte is decoded when the result register can take its outcome.
    assign step = item_valid && slot_free;

    tgard_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (step),
        .item_valid (item_valid),
        .item       (item)
    );

    tgard_parser #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    tgard_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind        = out_res.kind;
    assign width       = out_res.width;
    assign height      = out_res.height;
    assign pixel_bytes = out_res.pixel_bytes;
    assign pixel       = out_res.pixel;
    assign run_length  = out_res.run_length;
    assign last        = out_res.last;

endmodule

`default_nettype wire
